@@ rtl/core/two_class_pairing_queue_macros.svh @@
// ----------------------------------------------------------------------------
// two_class_pairing_queue_macros.svh
// Assertion macros shared by the pairing queue RTL. Each one samples on clk_i
// and is disabled while rst_ni is low. Defining ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PAIRING_QUEUE_MACROS_SVH
`define TWO_CLASS_PAIRING_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF

// expr holds at every clock edge out of reset
`define TCPQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// cons holds in the same cycle as ante
`define TCPQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`else

`define TCPQ_ASSERT_ALWAYS(label, expr, msg)
`define TCPQ_ASSERT_IMPL(label, ante, cons, msg)
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/core/tcpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tcpq_pkg
// Types, constants and helpers of the two-class pairing queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

  localparam int unsigned QUEUE_SLOTS = 128;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned PTR_BITS    = $clog2(QUEUE_SLOTS);

  typedef logic [TAG_BITS-1:0] tcpq_tag_t;
  typedef logic [PTR_BITS-1:0] tcpq_ptr_t;

  typedef enum logic [2:0] {
    KIND_PAIR        = 3'd0,
    KIND_WOMAN_WAITS = 3'd1,
    KIND_MAN_WAITS   = 3'd2,
    KIND_NOBODY      = 3'd3,
    KIND_DROPPED     = 3'd4
  } tcpq_kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SETTLE,
    S_REPORT
  } tcpq_state_e;

  // commands from the sequencer to one ring
  typedef struct packed {
    logic bump;   // count one more accepted arrival
    logic push;   // append the write tag at the tail
    logic pop;    // drop the head
    logic clear;  // end of batch: empty ring, zero count
  } tcpq_ring_cmd_t;

  // status of one ring back to the sequencer
  typedef struct packed {
    logic      empty;
    logic      full;      // batch limit of accepted arrivals reached
    tcpq_tag_t head_tag;  // registered read of the head entry
  } tcpq_ring_status_t;

  function automatic tcpq_ptr_t ptr_next(tcpq_ptr_t p);
    return (p == tcpq_ptr_t'(QUEUE_SLOTS - 1)) ? '0 : p + tcpq_ptr_t'(1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tcpq_if.sv @@
// ----------------------------------------------------------------------------
// tcpq_if
// Valid/ready channels of the pairing queue: arrivals in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcpq_in_if;
  import tcpq_pkg::*;

  logic      valid;
  logic      ready;
  logic      is_woman;
  tcpq_tag_t person_tag;
  logic      last_person;

  modport source (output valid, is_woman, person_tag, last_person, input ready);
  modport sink   (input valid, is_woman, person_tag, last_person, output ready);
endinterface

interface tcpq_out_if;
  import tcpq_pkg::*;

  logic       valid;
  logic       ready;
  tcpq_kind_e result_kind;
  tcpq_tag_t  woman_tag;
  tcpq_tag_t  man_tag;
  logic       last_of_run;

  modport source (output valid, result_kind, woman_tag, man_tag, last_of_run,
                  input ready);
  modport sink   (input valid, result_kind, woman_tag, man_tag, last_of_run,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/core/two_class_pairing_queue.sv @@
// ----------------------------------------------------------------------------
// two_class_pairing_queue
// Pairs arrivals of two classes in arrival order using one ring per class;
// the last arrival of a batch reports the first one left waiting.
// ----------------------------------------------------------------------------
//
//  channel | dir | word                                           | handshake
//  --------+-----+------------------------------------------------+----------
//  in_i    | in  | is_woman, person_tag, last_person              | valid/ready
//  out_o   | out | result_kind, woman_tag, man_tag, last_of_run   | valid/ready
//
//  Sequence: an arrival is accepted in idle and handled in execute; a last
//  arrival then also passes through settle and report before the next one.
//  Settle is needed because the head read of each ring memory is registered:
//  the head must be re-read after every pop or clear before use.
//  Reset: pointers, counts, sequencer and output valid clear at once; the
//  ring memories are not cleared (only entries written in a batch are read).
//  Stalls: a full output register holds the sequencer in execute or report;
//  arrivals are taken only in idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_class_pairing_queue_macros.svh"

module two_class_pairing_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcpq_in_if.sink   in_i,
  tcpq_out_if.source out_o
);
  import tcpq_pkg::*;

  // sequencer state
  tcpq_state_e state_q, state_d;

  // arrival under work (payload, no reset)
  logic      item_woman_q;
  tcpq_tag_t item_tag_q;
  logic      item_last_q;

  // ring interfaces
  tcpq_ring_cmd_t    w_cmd, m_cmd;
  tcpq_ring_status_t w_st, m_st;

  // output register
  logic       out_valid_q;
  tcpq_kind_e out_kind_q, kind_d;
  tcpq_tag_t  out_wtag_q, wtag_d;
  tcpq_tag_t  out_mtag_q, mtag_d;
  logic       out_last_q, last_d;
  logic       out_free;
  logic       load;
  logic       in_ready;

  // per-arrival view: own ring vs opposite ring
  logic      own_full;
  logic      other_empty;
  tcpq_tag_t partner_tag;

  assign out_free    = !out_valid_q || out_o.ready;
  assign own_full    = item_woman_q ? w_st.full  : m_st.full;
  assign other_empty = item_woman_q ? m_st.empty : w_st.empty;
  assign partner_tag = item_woman_q ? m_st.head_tag : w_st.head_tag;

  tcpq_ring u_woman_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (w_cmd),
    .wtag_i   (item_tag_q),
    .status_o (w_st)
  );

  tcpq_ring u_man_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (m_cmd),
    .wtag_i   (item_tag_q),
    .status_o (m_st)
  );

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    load     = 1'b0;
    kind_d   = KIND_PAIR;
    wtag_d   = '0;
    mtag_d   = '0;
    last_d   = 1'b0;
    w_cmd    = '0;
    m_cmd    = '0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          if (own_full) begin
            // class limit reached in this batch
            load   = 1'b1;
            kind_d = KIND_DROPPED;
            last_d = !item_last_q;
          end else if (!other_empty) begin
            // pair with the opposite head
            load   = 1'b1;
            kind_d = KIND_PAIR;
            last_d = !item_last_q;
            if (item_woman_q) begin
              wtag_d     = item_tag_q;
              mtag_d     = partner_tag;
              w_cmd.bump = 1'b1;
              m_cmd.pop  = 1'b1;
            end else begin
              wtag_d     = partner_tag;
              mtag_d     = item_tag_q;
              m_cmd.bump = 1'b1;
              w_cmd.pop  = 1'b1;
            end
          end else begin
            // nobody opposite: wait in own ring
            if (item_woman_q) begin
              w_cmd.bump = 1'b1;
              w_cmd.push = 1'b1;
            end else begin
              m_cmd.bump = 1'b1;
              m_cmd.push = 1'b1;
            end
          end
          state_d = item_last_q ? S_SETTLE : S_IDLE;
        end
      end
      S_SETTLE: begin
        // heads re-read after the update
        state_d = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          load   = 1'b1;
          last_d = 1'b1;
          if (!w_st.empty) begin
            kind_d = KIND_WOMAN_WAITS;
            wtag_d = w_st.head_tag;
          end else if (!m_st.empty) begin
            kind_d = KIND_MAN_WAITS;
            mtag_d = m_st.head_tag;
          end else begin
            kind_d = KIND_NOBODY;
          end
          w_cmd.clear = 1'b1;
          m_cmd.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      item_woman_q <= in_i.is_woman;
      item_tag_q   <= in_i.person_tag;
      item_last_q  <= in_i.last_person;
    end
    if (load) begin
      out_kind_q <= kind_d;
      out_wtag_q <= wtag_d;
      out_mtag_q <= mtag_d;
      out_last_q <= last_d;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.woman_tag   = out_wtag_q;
  assign out_o.man_tag     = out_mtag_q;
  assign out_o.last_of_run = out_last_q;

  `TCPQ_ASSERT_NEXT(a_accept_exec, in_i.valid && in_i.ready, state_q == S_EXEC,
                    "accepted word not executed next")
  `TCPQ_ASSERT_ALWAYS(a_one_side_waits, w_st.empty || m_st.empty,
                      "both classes waiting at once")
  `TCPQ_ASSERT_IMPL(a_report_closes, load && (kind_d == KIND_WOMAN_WAITS ||
                    kind_d == KIND_MAN_WAITS || kind_d == KIND_NOBODY), last_d,
                    "report word not last of run")
  `TCPQ_ASSERT_IMPL(a_load_free, load, out_free, "output word overwritten")

endmodule

`default_nettype wire

@@ rtl/core/tcpq_ring.sv @@
// ----------------------------------------------------------------------------
// tcpq_ring
// One circular queue of tags: storage memory, head/tail pointers and the
// per-batch count of accepted arrivals. Head entry read is registered.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_class_pairing_queue_macros.svh"

module tcpq_ring (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcpq_pkg::tcpq_ring_cmd_t   cmd_i,
  input  tcpq_pkg::tcpq_tag_t        wtag_i,
  output tcpq_pkg::tcpq_ring_status_t status_o
);
  import tcpq_pkg::*;

  tcpq_tag_t mem_q [QUEUE_SLOTS];
  tcpq_tag_t rtag_q;
  tcpq_ptr_t head_q, head_d;
  tcpq_ptr_t tail_q, tail_d;
  tcpq_ptr_t cnt_q, cnt_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (cmd_i.clear) begin
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
    end else begin
      if (cmd_i.pop)  head_d = ptr_next(head_q);
      if (cmd_i.push) tail_d = ptr_next(tail_q);
      if (cmd_i.bump) cnt_d  = cnt_q + tcpq_ptr_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // head read every cycle; a write into the head slot is forwarded
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem_q[tail_q] <= wtag_i;
    if (cmd_i.push && (tail_q == head_q)) begin
      rtag_q <= wtag_i;
    end else begin
      rtag_q <= mem_q[head_q];
    end
  end

  assign status_o.empty    = (head_q == tail_q);
  assign status_o.full     = (cnt_q == tcpq_ptr_t'(QUEUE_SLOTS - 1));
  assign status_o.head_tag = rtag_q;

  `TCPQ_ASSERT_IMPL(a_pop_nonempty, cmd_i.pop, !status_o.empty, "pop from empty ring")
  `TCPQ_ASSERT_IMPL(a_bump_not_full, cmd_i.bump, !status_o.full, "count past limit")
  `TCPQ_ASSERT_ALWAYS(a_no_push_pop, !(cmd_i.push && cmd_i.pop), "push and pop together")
  `TCPQ_ASSERT_NEXT(a_clear_empties, cmd_i.clear, status_o.empty && (cnt_q == '0),
                    "ring not empty after clear")

endmodule

`default_nettype wire

@@ test/tb_two_class_pairing_queue.sv @@
// ----------------------------------------------------------------------------
// tb_two_class_pairing_queue
// Self-checking bench for the two-class pairing queue. A short table of
// directed arrivals runs first, then random batches: well-formed ones,
// mostly small; long batches of mostly one class, sized around the
// per-class batch limit; and noise with stray last marks. A behavioral
// ring model predicts the words of every untyped arrival. The sender works
// in bursts with gaps and the receiver follows its own stall pattern.
// ----------------------------------------------------------------------------
module tb_two_class_pairing_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpq_pkg::*;

  localparam int unsigned ARRIVALS   = 1750;  // random arrivals to send
  localparam int unsigned STALL_LIMIT = 2000; // cycles with no word moved
  localparam int unsigned FILL_RUNS  = 6;     // long batches sized around the cap

  localparam logic CLASS_MAN   = 1'b0;
  localparam logic CLASS_WOMAN = 1'b1;
  localparam int unsigned MAN_Q   = 0;
  localparam int unsigned WOMAN_Q = 1;

  // one result word as seen on out_o
  typedef struct packed {
    tcpq_kind_e kind;
    tcpq_tag_t  woman_tag;
    tcpq_tag_t  man_tag;
    logic       last_of_run;
  } pair_result_t;

  // one directed arrival; want is used only where typed is set
  typedef struct packed {
    logic         is_woman;
    tcpq_tag_t    tag;
    logic         last_person;
    logic         typed;
    pair_result_t want;
  } dir_row_t;

  localparam pair_result_t NO_WANT = '{KIND_PAIR, 16'h0000, 16'h0000, 1'b0};

  // Directed arrivals. Typed rows follow a cleared batch, so their single
  // report word is plain to see; the rest are left to the ring model.
  localparam int unsigned DIR_ROWS = 18;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // lone man after reset, zero tag: he is reported waiting
    '{CLASS_MAN,   16'h0000, 1'b1, 1'b1, '{KIND_MAN_WAITS,   16'h0000, 16'h0000, 1'b1}},
    // lone woman, all-ones tag
    '{CLASS_WOMAN, 16'hFFFF, 1'b1, 1'b1, '{KIND_WOMAN_WAITS, 16'hFFFF, 16'h0000, 1'b1}},
    // woman waits, man pairs with her
    '{CLASS_WOMAN, 16'h1234, 1'b0, 1'b0, NO_WANT},
    '{CLASS_MAN,   16'hABCD, 1'b0, 1'b0, NO_WANT},
    // two men queue up, two women take them in order; last pair leaves nobody
    '{CLASS_MAN,   16'h5555, 1'b0, 1'b0, NO_WANT},
    '{CLASS_MAN,   16'hAAAA, 1'b0, 1'b0, NO_WANT},
    '{CLASS_WOMAN, 16'hFFFF, 1'b0, 1'b0, NO_WANT},
    '{CLASS_WOMAN, 16'h0000, 1'b1, 1'b0, NO_WANT},
    // pair on the last arrival, then nobody waiting
    '{CLASS_MAN,   16'h0001, 1'b0, 1'b0, NO_WANT},
    '{CLASS_WOMAN, 16'h8000, 1'b1, 1'b0, NO_WANT},
    // pair on the last arrival with one woman left over
    '{CLASS_WOMAN, 16'h0F0F, 1'b0, 1'b0, NO_WANT},
    '{CLASS_WOMAN, 16'hF0F0, 1'b0, 1'b0, NO_WANT},
    '{CLASS_MAN,   16'h1111, 1'b1, 1'b0, NO_WANT},
    // last arrival just waits: report only
    '{CLASS_WOMAN, 16'h7FFF, 1'b0, 1'b0, NO_WANT},
    '{CLASS_MAN,   16'h0000, 1'b0, 1'b0, NO_WANT},
    '{CLASS_MAN,   16'hFFFF, 1'b1, 1'b0, NO_WANT},
    // queues really were cleared by the last batch
    '{CLASS_MAN,   16'h2222, 1'b1, 1'b1, '{KIND_MAN_WAITS,   16'h0000, 16'h2222, 1'b1}},
    '{CLASS_WOMAN, 16'hC3C3, 1'b1, 1'b1, '{KIND_WOMAN_WAITS, 16'hC3C3, 16'h0000, 1'b1}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  tcpq_in_if  in_ch ();
  tcpq_out_if out_ch ();

  two_class_pairing_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Ring model: one circular queue per class plus the per-batch accept count.
  // Pointers restart at zero each batch, so only entries written in the
  // current batch are ever read back.
  // --------------------------------------------------------------------------
  tcpq_tag_t    ring_mem   [2][QUEUE_SLOTS];
  int unsigned  ring_head  [2];
  int unsigned  ring_tail  [2];
  int unsigned  ring_taken [2];
  pair_result_t fresh_q    [$];  // words caused by the arrival just taken
  pair_result_t pending_q  [$];  // words still owed by the block
  int unsigned  mismatch_count;

  function automatic int unsigned ring_adv(input int unsigned p);
    return (p + 1 >= QUEUE_SLOTS) ? 0 : p + 1;
  endfunction

  function automatic void clear_rings();
    for (int c = 0; c < 2; c++) begin
      ring_head[c]  = 0;
      ring_tail[c]  = 0;
      ring_taken[c] = 0;
    end
  endfunction

  // append one word to those caused by the current arrival
  function automatic void note_word(input pair_result_t w);
    fresh_q.insert(fresh_q.size(), w);
  endfunction

  // Fills fresh_q with the words one arrival causes and moves the rings on.
  function automatic void pair_arrival(input logic woman, input tcpq_tag_t tag,
                                       input logic last_person);
    int unsigned own;
    int unsigned other;
    tcpq_tag_t   partner;
    own   = woman ? WOMAN_Q : MAN_Q;
    other = woman ? MAN_Q : WOMAN_Q;
    fresh_q.delete();
    if (ring_taken[own] >= QUEUE_SLOTS - 1) begin
      // class already at its batch limit: dropped, takes no part in pairing
      note_word(pair_result_t'{KIND_DROPPED, '0, '0, 1'b0});
    end else begin
      ring_taken[own]++;
      if (ring_head[other] != ring_tail[other]) begin
        partner = ring_mem[other][ring_head[other]];
        ring_head[other] = ring_adv(ring_head[other]);
        if (woman) note_word(pair_result_t'{KIND_PAIR, tag, partner, 1'b0});
        else       note_word(pair_result_t'{KIND_PAIR, partner, tag, 1'b0});
      end else begin
        ring_mem[own][ring_tail[own]] = tag;
        ring_tail[own] = ring_adv(ring_tail[own]);
      end
    end
    if (last_person) begin
      // report: first waiting woman wins over first waiting man
      if (ring_head[WOMAN_Q] != ring_tail[WOMAN_Q])
        note_word(pair_result_t'{KIND_WOMAN_WAITS,
                                 ring_mem[WOMAN_Q][ring_head[WOMAN_Q]], '0, 1'b0});
      else if (ring_head[MAN_Q] != ring_tail[MAN_Q])
        note_word(pair_result_t'{KIND_MAN_WAITS, '0,
                                 ring_mem[MAN_Q][ring_head[MAN_Q]], 1'b0});
      else
        note_word(pair_result_t'{KIND_NOBODY, '0, '0, 1'b0});
      clear_rings();
    end
    if (fresh_q.size() != 0) fresh_q[fresh_q.size() - 1].last_of_run = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them. valid stays
  // high from one word to the next inside a burst, so the block sees
  // back-to-back words as well as gaps at every phase of its work.
  // --------------------------------------------------------------------------
  int unsigned burst_left;

  task automatic send_arrival(input logic woman, input tcpq_tag_t tag,
                              input logic last_person, input logic typed,
                              input pair_result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.is_woman    <= woman;
    in_ch.person_tag  <= tag;
    in_ch.last_person <= last_person;
    // sampled right at the edge, before the block updates
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pair_arrival(woman, tag, last_person);
    if (typed) pending_q.insert(pending_q.size(), want);
    else foreach (fresh_q[i]) pending_q.insert(pending_q.size(), fresh_q[i]);
  endtask

  // Hold the sender off until the block owes nothing; always spans an edge.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: always-ready stretches mixed with a rotating random stall
  // pattern; the pattern always has at least one ready slot, so stalls stay short.
  // --------------------------------------------------------------------------
  logic [7:0] stall_pattern = 8'hFF;
  logic [7:0] mode_left = 8'd0;
  logic       free_run = 1'b1;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      mode_left     <= 8'($urandom_range(16, 200));
      free_run      <= ($urandom_range(0, 2) == 0);
      stall_pattern <= 8'($urandom) | 8'h01;
    end else begin
      mode_left     <= mode_left - 8'd1;
      stall_pattern <= {stall_pattern[6:0], stall_pattern[7]};
    end
    out_ch.ready <= free_run | stall_pattern[7];
  end

  // --------------------------------------------------------------------------
  // Result checker: each word taken is matched against the oldest owed word.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pair_result_t got;
    pair_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.result_kind, out_ch.woman_tag, out_ch.man_tag, out_ch.last_of_run};
      if (pending_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word kind=%0d woman=%h man=%h last=%b", $time,
                 got.kind, got.woman_tag, got.man_tag, got.last_of_run);
      end else begin
        want = pending_q[0];
        pending_q.delete(0);
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: mismatch expected kind=%0d woman=%h man=%h last=%b", $time,
                   want.kind, want.woman_tag, want.man_tag, want.last_of_run);
          $display("%0t:          actual   kind=%0d woman=%h man=%h last=%b", $time,
                   got.kind, got.woman_tag, got.man_tag, got.last_of_run);
        end
      end
    end
  end

  // Watchdog: too long without a word moving on either channel.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d words owed", $time,
               idle_cycles, pending_q.size());
      $display("two_class_pairing_queue test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    int unsigned fills;
    int unsigned woman_pct;
    logic        cls;
    logic        woman;

    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.is_woman    = 1'b0;
    in_ch.person_tag  = '0;
    in_ch.last_person = 1'b0;
    out_ch.ready      = 1'b0;
    burst_left        = 0;
    mismatch_count    = 0;
    sent              = 0;
    fills             = 0;
    clear_rings();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int i = 0; i < DIR_ROWS; i++)
      send_arrival(DIR_TABLE[i].is_woman, DIR_TABLE[i].tag, DIR_TABLE[i].last_person,
                   DIR_TABLE[i].typed, DIR_TABLE[i].want);
    drain_results();

    // random part, one batch per pass
    while (sent < ARRIVALS) begin
      pick = $urandom_range(0, 99);
      if (fills == 0 || (pick < 8 && fills < FILL_RUNS)) begin
        // Long batch of mostly one class, sized around the batch limit.
        // The first one is pure and exactly one over, so the last arrival
        // itself is dropped ahead of the report.
        cls = 1'($urandom_range(0, 1));
        len = (fills == 0) ? QUEUE_SLOTS : QUEUE_SLOTS - 1 + $urandom_range(0, 4);
        for (int i = 0; i < len; i++) begin
          woman = (fills != 0 && $urandom_range(0, 9) == 0) ? !cls : cls;
          send_arrival(woman, tcpq_tag_t'($urandom), i == len - 1, 1'b0, NO_WANT);
        end
        fills++;
      end else if (pick < 20) begin
        // noise: last marks fall anywhere, batch may stay open
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          send_arrival(1'($urandom_range(0, 1)), tcpq_tag_t'($urandom),
                       $urandom_range(0, 3) == 0, 1'b0, NO_WANT);
      end else begin
        // well-formed batch with a class bias of its own
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
        woman_pct = $urandom_range(10, 90);
        for (int i = 0; i < len; i++)
          send_arrival($urandom_range(0, 99) < woman_pct, tcpq_tag_t'($urandom),
                       i == len - 1, 1'b0, NO_WANT);
      end
      sent += len;
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("two_class_pairing_queue test passed");
    end else begin
      $display("two_class_pairing_queue test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tcpq_pkg.sv
rtl/core/tcpq_if.sv
rtl/core/tcpq_ring.sv
rtl/core/two_class_pairing_queue.sv
test/tb_two_class_pairing_queue.sv
